@@ sv/atm_pkg.sv @@
// ----------------------------------------------------------------------------
// atm_pkg
// Shared types, opcodes and constants of the affine transform matrix unit.
// ----------------------------------------------------------------------------
package atm_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_COUNT       = 24;

  // 0.6072529 in Q2.30
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_SCALE  = 3'd1;
  localparam logic [2:0] OP_TRANS  = 3'd2;
  localparam logic [2:0] OP_YAW    = 3'd3;
  localparam logic [2:0] OP_PITCH  = 3'd4;
  localparam logic [2:0] OP_ROLL   = 3'd5;
  localparam logic [2:0] OP_AXIS   = 3'd6;
  localparam logic [2:0] OP_VERTEX = 3'd7;

  // Tag that travels with a product through the multiplier
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [1:0] row;
    logic [1:0] col;
  } atm_tag_t;

  // Request to the square root / divide unit
  typedef struct packed {
    logic start;
    logic div_mode;
  } atm_sd_req_t;

  // arctan(2^-i) in Q0.32 turns, binary angle units of 2^32 per full turn
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680350;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/atm_mul.sv @@
// ----------------------------------------------------------------------------
// atm_mul
// Shared 32x32 signed multiplier: a registered raw product, then from it a
// registered product rounded half up to FRAC_BITS, with a tag riding along.
// ----------------------------------------------------------------------------
module atm_mul import atm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [31:0]            a,
  input  logic signed [31:0]            b,
  input  atm_tag_t                      tag_i,
  output logic signed [63:0]            prod_o,
  output logic signed [63-FRAC_BITS:0]  rnd_o,
  output atm_tag_t                      tag_o,
  output logic                          busy_o
);

  localparam int RW = 64 - FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0]   prod_r;
  logic signed [RW-1:0] rnd_r;
  atm_tag_t             tag1_r, tag2_r;
  logic signed [63:0]   sum;
  logic signed [63:0]   shd;

  assign sum = prod_r + HALF;
  assign shd = sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    rnd_r  <= shd[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
    end
  end

  assign prod_o = prod_r;
  assign rnd_o  = rnd_r;
  assign tag_o  = tag2_r;
  assign busy_o = tag1_r.vld | tag2_r.vld;

endmodule

@@ sv/atm_cordic.sv @@
// ----------------------------------------------------------------------------
// atm_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle in Q2.30,
// then the quadrant is unfolded and the result rounded to FRAC_BITS.
// ----------------------------------------------------------------------------
module atm_cordic import atm_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        ang,
  output logic               busy,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int NSTEP = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int SH    = 30 - FRAC_BITS;
  localparam logic [4:0] LAST = 5'(NSTEP - 1);
  localparam logic signed [32:0] RND = 33'sd1 <<< (SH - 1);

  logic               run_r, fin_r, flip_r;
  logic [4:0]         it_r;
  logic signed [32:0] x_r, y_r, z_r;
  logic signed [31:0] cos_r, sin_r;

  logic [31:0]        ua, ua_q, ua2;
  logic               flip;
  logic signed [32:0] dx, dy, at, xf, yf, xr, yr;

  assign ua   = {ang, 16'h0000};
  assign ua_q = ua + 32'h4000_0000;
  assign flip = ua_q[31];
  assign ua2  = flip ? (ua ^ 32'h8000_0000) : ua;

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign at = $signed({1'b0, atan_val(it_r)});

  assign xf = flip_r ? -x_r : x_r;
  assign yf = flip_r ? -y_r : y_r;
  assign xr = (xf + RND) >>> SH;
  assign yr = (yf + RND) >>> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      it_r  <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      fin_r <= 1'b0;
      it_r  <= '0;
    end else if (run_r) begin
      it_r <= it_r + 5'd1;
      if (it_r == LAST) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end else begin
      fin_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed({ua2[31], ua2});
    end else if (run_r) begin
      if (!z_r[32]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (fin_r) begin
      cos_r <= xr[31:0];
      sin_r <= yr[31:0];
    end
  end

  assign busy  = run_r | fin_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

@@ sv/atm_sqdiv.sv @@
// ----------------------------------------------------------------------------
// atm_sqdiv
// Shared subtract-and-compare unit: a 64-bit integer square root at two bits
// a cycle, or a signed fixed-point divide (num << FRAC_BITS) / den, for |num|
// below 2*den, at one quotient bit a cycle.
// ----------------------------------------------------------------------------
module atm_sqdiv import atm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  atm_sd_req_t        req,
  input  logic [63:0]        rad,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  output logic               busy,
  output logic [31:0]        root,
  output logic signed [31:0] quot
);

  localparam logic [5:0] SQ_LAST  = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'(FRAC_BITS);

  logic               busy_r, mode_r, neg_r;
  logic [5:0]         cnt_r;
  logic [35:0]        rem_r;
  logic [31:0]        q_r, den_r;
  logic [63:0]        rad_r;

  logic [31:0]        anum;
  logic [35:0]        op_a, op_b;
  logic [36:0]        diff;
  logic               ge;

  assign anum = num[31] ? (32'd0 - num) : num;

  always_comb begin
    if (mode_r) begin
      op_a = {3'b000, rem_r[31:0], rad_r[63]};
      op_b = {4'b0000, den_r};
    end else begin
      op_a = {rem_r[33:0], rad_r[63:62]};
      op_b = {2'b00, q_r, 2'b01};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[36];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.div_mode ? DIV_LAST : SQ_LAST;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.div_mode;
      q_r    <= '0;
      den_r  <= den;
      neg_r  <= num[31];
      if (req.div_mode) begin
        rem_r <= {5'b00000, anum[31:1]};
        rad_r <= {anum[0], 63'd0};
      end else begin
        rem_r <= '0;
        rad_r <= rad;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[35:0] : op_a;
      q_r   <= {q_r[30:0], ge};
      rad_r <= mode_r ? {rad_r[62:0], 1'b0} : {rad_r[61:0], 2'b00};
    end
  end

  assign busy = busy_r;
  assign root = q_r;
  assign quot = neg_r ? (32'sd0 - $signed(q_r)) : $signed(q_r);

endmodule

@@ sv/affine_transform_matrix_unit_core.sv @@
// ----------------------------------------------------------------------------
// affine_transform_matrix_unit_core
// 4x4 Q16.16 homogeneous transform matrix with load, pre-multiply by scale,
// translation and rotations, and vertex transform, on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel | ports                        | moves
//  --------+------------------------------+------------------------------------
//  in      | in_valid / in_stall          | opcode, index, value, angle, x y z
//  out     | out_valid / out_stall        | result x y z, readback, null flag
//  cfg     | cfg_wr_en / cfg_wr_data      | zero snap threshold
//
//  Steps per beat: load writes the element, then readback and output; scale
//  or translate run 64 multiply-adds, a multiplier drain, readback, output;
//  yaw, pitch, roll first run the CORDIC; axis rotate first squares, roots
//  and divides the axis, or reads back at once if null; vertex runs 12 MACs.
//  Reset (rst_n low, synchronous) restores the identity matrix and threshold 1.
//  One beat is in flight at a time; in_stall stays high until the result beat
//  has been taken, so out_stall holds the whole block.
// ----------------------------------------------------------------------------
module affine_transform_matrix_unit_core import atm_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [3:0]         in_element_index,
  input  logic signed [31:0] in_element_value,
  input  logic signed [15:0] in_angle,
  input  logic signed [31:0] in_operand_x,
  input  logic signed [31:0] in_operand_y,
  input  logic signed [31:0] in_operand_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_x,
  output logic signed [31:0] out_result_y,
  output logic signed [31:0] out_result_z,
  output logic signed [31:0] out_element_readback,
  output logic               out_axis_was_null,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam int RW = 64 - FRAC_BITS;
  localparam int AW = RW + 2;
  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [AW-1:0] SAT_HI = AW'(64'sh7fff_ffff);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CORD  = 11'b000_0000_0010,
    S_SQR   = 11'b000_0000_0100,
    S_SQRT  = 11'b000_0000_1000,
    S_DIV   = 11'b000_0001_0000,
    S_AXM   = 11'b000_0010_0000,
    S_AXB   = 11'b000_0100_0000,
    S_MAT   = 11'b000_1000_0000,
    S_DRAIN = 11'b001_0000_0000,
    S_RDBK  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] thr_r, thr_nxt;
  logic signed [31:0] mat_r [16];
  logic signed [31:0] mat_nxt [16];
  logic out_valid_r, out_valid_nxt;
  atm_tag_t acct_r, acct_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] ang_r, ang_nxt;
  logic signed [31:0] ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic vtx_r, vtx_nxt, null_r, null_nxt;
  logic signed [31:0] r_r [16];
  logic signed [31:0] r_nxt [16];
  logic signed [31:0] scr_r [15];
  logic signed [31:0] scr_nxt [15];
  logic signed [31:0] tmp_r [3];
  logic signed [31:0] tmp_nxt [3];
  logic signed [31:0] res_r [3];
  logic signed [31:0] res_nxt [3];
  logic signed [31:0] nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt;
  logic [31:0] len_r, len_nxt;
  logic [63:0] sq_r, sq_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [31:0] ox_out_r, oy_out_r, oz_out_r, rb_out_r;
  logic signed [31:0] ox_out_nxt, oy_out_nxt, oz_out_nxt, rb_out_nxt;
  logic null_out_r, null_out_nxt;

  logic signed [31:0] mul_a, mul_b;
  atm_tag_t mul_tag_i, mul_tag_o;
  logic signed [63:0] mul_prod;
  logic signed [RW-1:0] mul_rnd;
  logic mul_busy;

  logic cord_start, cord_busy;
  logic [15:0] cord_ang;
  logic signed [31:0] cord_cos, cord_sin, tcoef;

  atm_sd_req_t sd_req;
  logic [63:0] sd_rad;
  logic signed [31:0] sd_num, sd_quot;
  logic sd_busy;
  logic [31:0] sd_root;

  logic [1:0] ii, kk, jj;
  logic [3:0] rd_addr;
  logic signed [31:0] mat_rd, vk;
  logic signed [AW-1:0] rnd_ext, mag, snapped, sat_in;
  logic signed [31:0] fin_val;
  logic [4:0] scr_idx;

  atm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .a      (mul_a),
    .b      (mul_b),
    .tag_i  (mul_tag_i),
    .prod_o (mul_prod),
    .rnd_o  (mul_rnd),
    .tag_o  (mul_tag_o),
    .busy_o (mul_busy)
  );

  atm_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .ang   (cord_ang),
    .busy  (cord_busy),
    .cos_o (cord_cos),
    .sin_o (cord_sin)
  );

  atm_sqdiv #(.FRAC_BITS(FRAC_BITS)) u_sqdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sd_req),
    .rad   (sd_rad),
    .num   (sd_num),
    .den   (len_r),
    .busy  (sd_busy),
    .root  (sd_root),
    .quot  (sd_quot)
  );

  assign ii      = cnt_r[3:2];
  assign kk      = cnt_r[1:0];
  assign jj      = cnt_r[5:4];
  assign rd_addr = (state_r == S_RDBK) ? idx_r : (vtx_r ? {ii, kk} : {kk, jj});
  assign mat_rd  = mat_r[rd_addr];
  assign tcoef   = FX_ONE - cord_cos;
  assign rnd_ext = {{2{mul_rnd[RW-1]}}, mul_rnd};
  assign scr_idx = cnt_r[4:0] - 5'd2;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    case (kk)
      2'd0:    vk = ox_r;
      2'd1:    vk = oy_r;
      2'd2:    vk = oz_r;
      default: vk = FX_ONE;
    endcase
  end

  // Snap and saturate the finished sum; vertex sums only saturate
  always_comb begin
    mag     = acc_r[AW-1] ? -acc_r : acc_r;
    snapped = (mag <= $signed({{(AW-16){1'b0}}, thr_r})) ? '0 : acc_r;
    sat_in  = vtx_r ? acc_r : snapped;
    if (sat_in > SAT_HI) begin
      fin_val = 32'sh7fff_ffff;
    end else if (sat_in < SAT_LO) begin
      fin_val = 32'sh8000_0000;
    end else begin
      fin_val = sat_in[31:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    mat_nxt       = mat_r;
    out_valid_nxt = out_valid_r;
    op_nxt  = op_r;
    idx_nxt = idx_r;
    ang_nxt = ang_r;
    ox_nxt  = ox_r;
    oy_nxt  = oy_r;
    oz_nxt  = oz_r;
    vtx_nxt = vtx_r;
    null_nxt = null_r;
    r_nxt   = r_r;
    scr_nxt = scr_r;
    tmp_nxt = tmp_r;
    res_nxt = res_r;
    nx_nxt  = nx_r;
    ny_nxt  = ny_r;
    nz_nxt  = nz_r;
    len_nxt = len_r;
    sq_nxt  = sq_r;
    ox_out_nxt = ox_out_r;
    oy_out_nxt = oy_out_r;
    oz_out_nxt = oz_out_r;
    rb_out_nxt = rb_out_r;
    null_out_nxt = null_out_r;
    mul_a      = '0;
    mul_b      = '0;
    mul_tag_i  = '0;
    cord_start = 1'b0;
    cord_ang   = ang_r;
    sd_req     = '0;
    sd_rad     = sq_r + mul_prod;
    sd_num     = ox_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_opcode;
          idx_nxt  = in_element_index;
          ang_nxt  = in_angle;
          ox_nxt   = in_operand_x;
          oy_nxt   = in_operand_y;
          oz_nxt   = in_operand_z;
          vtx_nxt  = 1'b0;
          null_nxt = 1'b0;
          cnt_nxt  = '0;
          for (int n = 0; n < 3; n++) begin
            res_nxt[n] = '0;
          end
          for (int n = 0; n < 16; n++) begin
            r_nxt[n] = (n % 5 == 0) ? FX_ONE : '0;
          end
          case (in_opcode)
            OP_LOAD: begin
              mat_nxt[in_element_index] = in_element_value;
              state_nxt = S_RDBK;
            end
            OP_SCALE: begin
              r_nxt[0]  = in_operand_x;
              r_nxt[5]  = in_operand_y;
              r_nxt[10] = in_operand_z;
              state_nxt = S_MAT;
            end
            OP_TRANS: begin
              r_nxt[3]  = in_operand_x;
              r_nxt[7]  = in_operand_y;
              r_nxt[11] = in_operand_z;
              state_nxt = S_MAT;
            end
            OP_YAW, OP_PITCH, OP_ROLL: begin
              cord_start = 1'b1;
              cord_ang   = 16'd0 - in_angle;
              state_nxt  = S_CORD;
            end
            OP_AXIS: begin
              state_nxt = S_SQR;
            end
            default: begin
              vtx_nxt   = 1'b1;
              state_nxt = S_MAT;
            end
          endcase
        end
      end

      S_CORD: begin
        if (!cord_busy) begin
          case (op_r)
            OP_YAW: begin
              r_nxt[0]  = cord_cos;
              r_nxt[2]  = cord_sin;
              r_nxt[8]  = -cord_sin;
              r_nxt[10] = cord_cos;
            end
            OP_PITCH: begin
              r_nxt[5]  = cord_cos;
              r_nxt[6]  = -cord_sin;
              r_nxt[9]  = cord_sin;
              r_nxt[10] = cord_cos;
            end
            default: begin
              r_nxt[0] = cord_cos;
              r_nxt[1] = -cord_sin;
              r_nxt[4] = cord_sin;
              r_nxt[5] = cord_cos;
            end
          endcase
          cnt_nxt   = '0;
          state_nxt = S_MAT;
        end
      end

      // Sum of the three squared axis components, then start its square root
      S_SQR: begin
        case (kk)
          2'd0: begin
            mul_a = ox_r;
            mul_b = ox_r;
          end
          2'd1: begin
            mul_a = oy_r;
            mul_b = oy_r;
          end
          2'd2: begin
            mul_a = oz_r;
            mul_b = oz_r;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        if (kk == 2'd1) begin
          sq_nxt = mul_prod;
        end else if (kk == 2'd2) begin
          sq_nxt = sq_r + mul_prod;
        end
        if (kk == 2'd3) begin
          sd_req.start    = 1'b1;
          sd_req.div_mode = 1'b0;
          state_nxt       = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      S_SQRT: begin
        if (!sd_busy) begin
          if (sd_root <= {16'h0000, thr_r}) begin
            null_nxt  = 1'b1;
            state_nxt = S_RDBK;
          end else begin
            len_nxt    = sd_root;
            cord_start = 1'b1;
            cnt_nxt    = '0;
            state_nxt  = S_DIV;
          end
        end
      end

      // Even steps start a component divide, odd steps collect it
      S_DIV: begin
        case (cnt_r[2:0])
          3'd0, 3'd2, 3'd4: begin
            sd_req.start    = 1'b1;
            sd_req.div_mode = 1'b1;
            sd_num = (cnt_r[2:0] == 3'd0) ? ox_r : ((cnt_r[2:0] == 3'd2) ? oy_r : oz_r);
            cnt_nxt = cnt_r + 6'd1;
          end
          3'd1: begin
            if (!sd_busy) begin
              nx_nxt  = sd_quot;
              cnt_nxt = cnt_r + 6'd1;
            end
          end
          3'd3: begin
            if (!sd_busy) begin
              ny_nxt  = sd_quot;
              cnt_nxt = cnt_r + 6'd1;
            end
          end
          default: begin
            if (!sd_busy) begin
              nz_nxt = sd_quot;
              if (!cord_busy) begin
                cnt_nxt   = '0;
                state_nxt = S_AXM;
              end
            end
          end
        endcase
      end

      // Axis rotation terms; each rounded product is stored in scr_r as it leaves the multiplier
      S_AXM: begin
        case (cnt_r[3:0])
          4'd0: begin mul_a = nx_r; mul_b = nx_r; end
          4'd1: begin mul_a = ny_r; mul_b = ny_r; end
          4'd2: begin mul_a = nz_r; mul_b = nz_r; end
          4'd3: begin mul_a = nx_r; mul_b = ny_r; end
          4'd4: begin mul_a = nx_r; mul_b = nz_r; end
          4'd5: begin mul_a = ny_r; mul_b = nz_r; end
          4'd6: begin mul_a = scr_r[0]; mul_b = tcoef; end
          4'd7: begin mul_a = scr_r[1]; mul_b = tcoef; end
          4'd8: begin mul_a = scr_r[2]; mul_b = tcoef; end
          4'd9: begin mul_a = scr_r[3]; mul_b = tcoef; end
          4'd10: begin mul_a = scr_r[4]; mul_b = tcoef; end
          4'd11: begin mul_a = scr_r[5]; mul_b = tcoef; end
          4'd12: begin mul_a = nz_r; mul_b = cord_sin; end
          4'd13: begin mul_a = ny_r; mul_b = cord_sin; end
          4'd14: begin mul_a = nx_r; mul_b = cord_sin; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_r >= 6'd2) begin
          scr_nxt[scr_idx[3:0]] = mul_rnd[31:0];
        end
        if (cnt_r == 6'd16) begin
          state_nxt = S_AXB;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      S_AXB: begin
        r_nxt[0]  = scr_r[6] + cord_cos;
        r_nxt[1]  = scr_r[9] - scr_r[12];
        r_nxt[2]  = scr_r[10] + scr_r[13];
        r_nxt[4]  = scr_r[9] + scr_r[12];
        r_nxt[5]  = scr_r[7] + cord_cos;
        r_nxt[6]  = scr_r[11] - scr_r[14];
        r_nxt[8]  = scr_r[10] - scr_r[13];
        r_nxt[9]  = scr_r[11] + scr_r[14];
        r_nxt[10] = scr_r[8] + cord_cos;
        cnt_nxt   = '0;
        state_nxt = S_MAT;
      end

      // Issue one multiply-add a cycle: column, row, then inner index
      S_MAT: begin
        mul_a           = vtx_r ? mat_rd : r_r[{ii, kk}];
        mul_b           = vtx_r ? vk : mat_rd;
        mul_tag_i.vld   = 1'b1;
        mul_tag_i.first = (kk == 2'd0);
        mul_tag_i.last  = (kk == 2'd3);
        mul_tag_i.row   = ii;
        mul_tag_i.col   = jj;
        if (cnt_r == (vtx_r ? 6'd11 : 6'd63)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      S_DRAIN: begin
        if (!mul_busy && !mul_tag_o.vld && !acct_r.vld) begin
          state_nxt = S_RDBK;
        end
      end

      S_RDBK: begin
        ox_out_nxt    = res_r[0];
        oy_out_nxt    = res_r[1];
        oz_out_nxt    = res_r[2];
        rb_out_nxt    = mat_rd;
        null_out_nxt  = null_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Accumulate rounded products
    acct_nxt     = mul_tag_o;
    acct_nxt.vld = mul_tag_o.vld & mul_tag_o.last;
    acc_nxt      = acc_r;
    if (mul_tag_o.vld) begin
      acc_nxt = mul_tag_o.first ? rnd_ext : (acc_r + rnd_ext);
    end

    // Retire a finished sum; in matrix mode the bottom row writes the whole column back
    if (acct_r.vld) begin
      if (vtx_r) begin
        if (acct_r.row != 2'd3) begin
          res_nxt[acct_r.row] = fin_val;
        end
      end else if (acct_r.row != 2'd3) begin
        tmp_nxt[acct_r.row] = fin_val;
      end else begin
        mat_nxt[{2'd0, acct_r.col}] = tmp_r[0];
        mat_nxt[{2'd1, acct_r.col}] = tmp_r[1];
        mat_nxt[{2'd2, acct_r.col}] = tmp_r[2];
        mat_nxt[{2'd3, acct_r.col}] = fin_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      thr_r       <= 16'd1;
      out_valid_r <= 1'b0;
      acct_r      <= '0;
      for (int n = 0; n < 16; n++) begin
        mat_r[n] <= (n % 5 == 0) ? FX_ONE : '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
      acct_r      <= acct_nxt;
      mat_r       <= mat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    idx_r  <= idx_nxt;
    ang_r  <= ang_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    oz_r   <= oz_nxt;
    vtx_r  <= vtx_nxt;
    null_r <= null_nxt;
    r_r    <= r_nxt;
    scr_r  <= scr_nxt;
    tmp_r  <= tmp_nxt;
    res_r  <= res_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    nz_r   <= nz_nxt;
    len_r  <= len_nxt;
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
    ox_out_r   <= ox_out_nxt;
    oy_out_r   <= oy_out_nxt;
    oz_out_r   <= oz_out_nxt;
    rb_out_r   <= rb_out_nxt;
    null_out_r <= null_out_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_result_x         = ox_out_r;
  assign out_result_y         = oy_out_r;
  assign out_result_z         = oz_out_r;
  assign out_element_readback = rb_out_r;
  assign out_axis_was_null    = null_out_r;

endmodule
